// ----- rtl/rmn_pkg.sv -----
// rmn_pkg: types, constants and table lookups for the Roman numeral encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rmn_pkg;

  localparam int VALUE_W  = 16;
  localparam int REM_W    = 12;   // holds 1 .. 3999
  localparam int IDX_W    = 4;    // 13 table entries
  localparam int LETTER_W = 7;
  localparam int STATUS_W = 2;

  localparam logic [VALUE_W-1:0]  LIMIT_VALUE = 16'd3999;
  localparam logic [IDX_W-1:0]    IDX_LAST    = 4'd12;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic [LETTER_W-1:0] CHR_NONE = 7'h00;
  localparam logic [LETTER_W-1:0] CHR_I    = 7'h49;
  localparam logic [LETTER_W-1:0] CHR_V    = 7'h56;
  localparam logic [LETTER_W-1:0] CHR_X    = 7'h58;
  localparam logic [LETTER_W-1:0] CHR_L    = 7'h4C;
  localparam logic [LETTER_W-1:0] CHR_C    = 7'h43;
  localparam logic [LETTER_W-1:0] CHR_D    = 7'h44;
  localparam logic [LETTER_W-1:0] CHR_M    = 7'h4D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL
  } state_t;

  // What the shared compare/subtract unit hands to the sequencer.
  typedef struct packed {
    logic                ge;        // remainder >= table step
    logic [REM_W-1:0]    diff;      // remainder - step
    logic [LETTER_W-1:0] lead;      // first letter of the entry
    logic [LETTER_W-1:0] tail;      // second letter of a pair entry
    logic                has_tail;
  } step_res_t;

  function automatic logic [REM_W-1:0] step_val(input logic [IDX_W-1:0] idx);
    logic [REM_W-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [LETTER_W-1:0] lead_chr(input logic [IDX_W-1:0] idx);
    logic [LETTER_W-1:0] c;
    case (idx)
      4'd0:                      c = CHR_M;
      4'd1, 4'd3, 4'd4:          c = CHR_C;
      4'd2:                      c = CHR_D;
      4'd5, 4'd7, 4'd8:          c = CHR_X;
      4'd6:                      c = CHR_L;
      4'd10:                     c = CHR_V;
      default:                   c = CHR_I;
    endcase
    return c;
  endfunction

  function automatic logic [LETTER_W-1:0] tail_chr(input logic [IDX_W-1:0] idx);
    logic [LETTER_W-1:0] c;
    case (idx)
      4'd1:    c = CHR_M;
      4'd3:    c = CHR_D;
      4'd5:    c = CHR_C;
      4'd7:    c = CHR_L;
      4'd9:    c = CHR_X;
      4'd11:   c = CHR_V;
      default: c = CHR_NONE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/rmn_step_unit.sv -----
// rmn_step_unit: shared compare/subtract against the current table entry.
// Depends on rmn_pkg.
`timescale 1ns / 1ps

module rmn_step_unit
  import rmn_pkg::*;
(
  input  logic [REM_W-1:0] rem,
  input  logic [IDX_W-1:0] idx,
  output step_res_t        res
);

  logic [REM_W-1:0] step;

  assign step = step_val(idx);

  always_comb begin
    res.ge       = (rem >= step);
    res.diff     = rem - step;
    res.lead     = lead_chr(idx);
    res.tail     = tail_chr(idx);
    res.has_tail = (tail_chr(idx) != CHR_NONE);
  end

endmodule

// ----- rtl/rmn_seq.sv -----
// rmn_seq: sequencer walking the table, holding remainder and result registers.
// Depends on rmn_pkg; drives rmn_step_unit through rem/idx.
`timescale 1ns / 1ps

module rmn_seq
  import rmn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [VALUE_W-1:0]  value,
  output logic                busy,
  output logic [REM_W-1:0]    rem,
  output logic [IDX_W-1:0]    idx,
  input  step_res_t           res,
  output logic                strobe,
  output logic [LETTER_W-1:0] letter,
  output logic                last,
  output logic [STATUS_W-1:0] status
);

  state_t              state, state_next;
  logic [REM_W-1:0]    rem_next;
  logic [IDX_W-1:0]    idx_next;
  logic                strobe_next;
  logic [LETTER_W-1:0] letter_next;
  logic                last_next;
  logic [STATUS_W-1:0] status_next;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
    rem    <= rem_next;
    idx    <= idx_next;
    letter <= letter_next;
    last   <= last_next;
    status <= status_next;
  end

  always_comb begin
    state_next  = state;
    rem_next    = rem;
    idx_next    = idx;
    strobe_next = 1'b0;
    letter_next = letter;
    last_next   = last;
    status_next = status;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (value == '0) begin
            strobe_next = 1'b1;
            letter_next = CHR_NONE;
            last_next   = 1'b1;
            status_next = STATUS_EMPTY;
          end else if (value > LIMIT_VALUE) begin
            strobe_next = 1'b1;
            letter_next = CHR_NONE;
            last_next   = 1'b1;
            status_next = STATUS_RANGE;
          end else begin
            rem_next   = value[REM_W-1:0];
            idx_next   = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (res.ge) begin
          strobe_next = 1'b1;
          letter_next = res.lead;
          status_next = STATUS_OK;
          rem_next    = res.diff;
          last_next   = !res.has_tail && (res.diff == '0);
          if (res.has_tail) begin
            state_next = ST_TAIL;
          end else if (res.diff == '0) begin
            state_next = ST_IDLE;
          end
        end else if (idx != IDX_LAST) begin
          idx_next = idx + 1'b1;
        end
      end
      ST_TAIL: begin
        // remainder already reduced by the pair's value
        strobe_next = 1'b1;
        letter_next = res.tail;
        status_next = STATUS_OK;
        last_next   = (rem == '0);
        if (rem == '0) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN;
          if (idx != IDX_LAST) begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/integer_to_roman_encoder_core.sv -----
// integer_to_roman_encoder_core: top level of the Roman numeral encoder.
// Depends on rmn_pkg, rmn_step_unit and rmn_seq.
`timescale 1ns / 1ps
//
// Channel  | Ports                          | Beat taken when
// ---------+--------------------------------+--------------------------------
// command  | start, value[15:0], busy       | start high and busy low
// result   | strobe, letter[6:0], last,     | every cycle strobe is high
//          | status[1:0]                    | (single-cycle beats, no stall)
//
// Zero and values above 3999 give a single result beat in the cycle after
// the command beat. Otherwise the sequencer walks the table top-down, each
// cycle either emitting a letter or stepping past a table entry, all through
// the single shared compare/subtract unit.
// Reset: synchronous, active high; returns the sequencer to idle and drops
// strobe. Busy is high while a nonzero value up to 3999 is being encoded.
// The receiver cannot stall: each result is on the ports for one cycle only.

module integer_to_roman_encoder_core
  import rmn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [VALUE_W-1:0]  value,
  output logic                busy,
  output logic                strobe,
  output logic [LETTER_W-1:0] letter,
  output logic                last,
  output logic [STATUS_W-1:0] status
);

  logic [REM_W-1:0] rem;
  logic [IDX_W-1:0] idx;
  step_res_t        res;

  // Greedy step: compare remainder with the current table entry and
  // supply the entry's letters.
  rmn_step_unit u_step (
    .rem (rem),
    .idx (idx),
    .res (res)
  );

  // Walks the table top-down, one letter or one entry advance per cycle,
  // and registers every result beat.
  rmn_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (value),
    .busy   (busy),
    .rem    (rem),
    .idx    (idx),
    .res    (res),
    .strobe (strobe),
    .letter (letter),
    .last   (last),
    .status (status)
  );

endmodule
